// File: sv/tsue_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsue_pkg: shared types and constants
// Field widths, register map codes, command codes and sequencer states for
// the tabular SARSA update engine.
// ----------------------------------------------------------------------------
package tsue_pkg;

    // beat field widths
    localparam int ACTION_W = 2;
    localparam int POS_W    = 6;
    localparam int VEL_W    = 7;
    localparam int REWARD_W = 32;
    localparam int RND_W    = 4;
    localparam int CHOICE_W = 4;

    // table entry, signed Q16.16
    localparam int Q_W = 32;

    // configuration port
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;
    localparam int REG_LSB = 2;

    localparam logic [15:0] STEP_SIZE_RST = 16'd6554;
    localparam logic [15:0] DISCOUNT_RST  = 16'd32768;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_END   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        REG_STEP_SIZE = 2'd0,
        REG_DISCOUNT  = 2'd1,
        REG_FROZEN    = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ROW,
        S_BASE,
        S_SCAN,
        S_LAST,
        S_NEXT,
        S_PREV,
        S_MUL1,
        S_DIFF,
        S_MUL2,
        S_WB
    } t_state;

endpackage
`default_nettype wire

// File: sv/tsue_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsue_req_if / tsue_res_if: valid/ready channels
// Request channel carries one command beat, result channel one chosen action.
// ----------------------------------------------------------------------------
interface tsue_req_if import tsue_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [POS_W-1:0]           position;
    logic signed [VEL_W-1:0]    velocity;
    logic signed [REWARD_W-1:0] reward;
    logic [RND_W-1:0]           random_choice;

    modport source (
        output valid, action, position, velocity, reward, random_choice,
        input  ready
    );
    modport sink (
        input  valid, action, position, velocity, reward, random_choice,
        output ready
    );
endinterface

interface tsue_res_if import tsue_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CHOICE_W-1:0] chosen_action;

    modport source (
        output valid, chosen_action,
        input  ready
    );
    modport sink (
        input  valid, chosen_action,
        output ready
    );
endinterface
`default_nettype wire

// File: sv/tabular_sarsa_update_engine_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tabular_sarsa_update_engine_top: greedy action choice and SARSA table update
// Q-table in one single-port RAM, scanned and updated by a small sequencer
// around one shared multiplier and one shared signed comparator.
// ----------------------------------------------------------------------------
// Usage:
//   i_req takes a command beat (start, step, end); start and step return one
//   beat on o_res with the chosen action, end returns nothing. Command code 3
//   is dropped without effect. Registers are to be written over the APB-style
//   port only while the engine is idle; the block itself does not enforce this.
//   After reset the table is swept to zero, one entry a cycle, over all
//   NUM_POSITIONS*NUM_VELOCITIES*NUM_ACTIONS entries (56661 by default);
//   i_req.ready stays low meanwhile, register writes are taken as usual.
//   One command at a time: i_req.ready is high only between commands.
//   A start runs the row scan and reads the chosen entry, then returns its
//   result in the write-back step without a table write; a step also reads
//   the previous entry and makes two passes through the shared multiplier
//   before write-back; an end reads the previous entry and makes the two
//   multiplier passes. The scan reads one entry per action on the one RAM port.
//   The result beat sits in an output register; the engine takes the next
//   command while it waits. If o_res is stalled and a further result is due,
//   the engine holds in its write-back step until the register drains.
// ----------------------------------------------------------------------------
module tabular_sarsa_update_engine_top import tsue_pkg::*; #(
    parameter int NUM_ACTIONS    = 11,
    parameter int NUM_POSITIONS  = 51,
    parameter int NUM_VELOCITIES = 101
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    tsue_req_if.sink            i_req,
    tsue_res_if.source          o_res,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [APB_AW-1:0]   paddr,
    input  wire  [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int TD   = NUM_POSITIONS * NUM_VELOCITIES * NUM_ACTIONS;
    localparam int TW   = $clog2(TD);
    localparam int AW   = $clog2(NUM_ACTIONS);
    localparam int PW   = $clog2(NUM_POSITIONS);
    localparam int VW   = $clog2(NUM_VELOCITIES);
    localparam int RW   = $clog2(NUM_POSITIONS * NUM_VELOCITIES);
    localparam int VOFF = NUM_VELOCITIES / 2;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [15:0] r_step_size;
    logic [15:0] r_discount;
    logic        r_frozen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size <= STEP_SIZE_RST;
            r_discount  <= DISCOUNT_RST;
            r_frozen    <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (t_reg_idx'(paddr[REG_LSB+1:REG_LSB]))
                REG_STEP_SIZE: r_step_size <= pwdata[15:0];
                REG_DISCOUNT:  r_discount  <= pwdata[15:0];
                REG_FROZEN:    r_frozen    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[REG_LSB+1:REG_LSB]))
            REG_STEP_SIZE: prdata = {16'd0, r_step_size};
            REG_DISCOUNT:  prdata = {16'd0, r_discount};
            REG_FROZEN:    prdata = {31'd0, r_frozen};
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    t_state                  r_state, n_state;
    logic [TW-1:0]           r_clr;
    logic [TW-1:0]           r_prev_addr;
    logic [ACTION_W-1:0]     r_cmd;
    logic [PW-1:0]           r_pos;
    logic [VW-1:0]           r_vi;
    logic [AW-1:0]           r_rnd;
    logic signed [31:0]      r_reward;
    logic [RW-1:0]           r_row;
    logic [TW-1:0]           r_base;
    logic [AW-1:0]           r_idx;
    logic [AW-1:0]           r_cmp_idx;
    logic                    r_dv;
    logic signed [Q_W-1:0]   r_best_val;
    logic [AW-1:0]           r_best_idx;
    logic [AW-1:0]           r_act;
    logic signed [Q_W-1:0]   r_qnext;
    logic signed [Q_W-1:0]   r_q;
    logic signed [50:0]      r_prod;
    logic signed [33:0]      r_d16;
    logic signed [Q_W-1:0]   r_rdata;
    logic                    r_out_valid;
    logic [CHOICE_W-1:0]     r_out_act;

    logic [Q_W-1:0]          mem [TD];

    // ------------------------------------------------------------------
    // input clamping
    // ------------------------------------------------------------------
    logic              w_in_fire;
    logic signed [9:0] w_vi_s;
    logic [PW-1:0]     w_pos_c;
    logic [VW-1:0]     w_vi_c;
    logic [AW-1:0]     w_rnd_c;

    assign w_in_fire = i_req.valid && i_req.ready;
    assign w_vi_s    = {{3{i_req.velocity[VEL_W-1]}}, i_req.velocity} + 10'(VOFF);

    always_comb begin
        if ({3'b000, i_req.position} > 9'(NUM_POSITIONS - 1)) begin
            w_pos_c = PW'(NUM_POSITIONS - 1);
        end else begin
            w_pos_c = PW'(i_req.position);
        end
        if (w_vi_s[9]) begin
            w_vi_c = '0;
        end else if (w_vi_s > $signed(10'(NUM_VELOCITIES - 1))) begin
            w_vi_c = VW'(NUM_VELOCITIES - 1);
        end else begin
            w_vi_c = VW'(w_vi_s);
        end
        if ({1'b0, i_req.random_choice} > 5'(NUM_ACTIONS - 1)) begin
            w_rnd_c = AW'(NUM_ACTIONS - 1);
        end else begin
            w_rnd_c = AW'(i_req.random_choice);
        end
    end

    // ------------------------------------------------------------------
    // shared multiplier and comparator, update arithmetic
    // ------------------------------------------------------------------
    logic signed [16:0] w_mul_a;
    logic signed [33:0] w_mul_b;
    logic signed [50:0] w_prod;
    logic signed [50:0] w_prod_rnd;
    logic signed [33:0] w_d16;
    logic signed [34:0] w_nv;
    logic signed [Q_W-1:0] w_nv_sat;
    logic signed [Q_W-1:0] w_cmp_a;
    logic signed [Q_W-1:0] w_cmp_b;
    logic              w_gt;
    logic [AW-1:0]     w_choice;
    logic              w_wb_stall;

    assign w_mul_a = (r_state == S_MUL2) ? $signed({1'b0, r_step_size})
                                         : $signed({1'b0, r_discount});
    assign w_mul_b = (r_state == S_MUL2) ? r_d16
                                         : $signed({{2{r_qnext[Q_W-1]}}, r_qnext});
    assign w_prod  = w_mul_a * w_mul_b;

    // round to nearest, ties up: floor((x + 2^15) / 2^16)
    assign w_prod_rnd = r_prod + 51'sd32768;

    assign w_d16 = $signed({{2{r_reward[31]}}, r_reward})
                 - $signed({{2{r_q[Q_W-1]}}, r_q})
                 + $signed(w_prod_rnd[49:16]);

    assign w_nv = $signed({{3{r_q[Q_W-1]}}, r_q}) + $signed(w_prod_rnd[50:16]);

    always_comb begin
        if (w_nv > 35'sh0_7FFF_FFFF) begin
            w_nv_sat = 32'sh7FFF_FFFF;
        end else if (w_nv < -35'sh0_8000_0000) begin
            w_nv_sat = 32'sh8000_0000;
        end else begin
            w_nv_sat = w_nv[Q_W-1:0];
        end
    end

    assign w_cmp_a = (r_state == S_WB) ? w_nv_sat : r_rdata;
    assign w_cmp_b = (r_state == S_WB) ? r_q      : r_best_val;
    assign w_gt    = w_cmp_a > w_cmp_b;

    // a zero maximum hands the choice to the random action
    assign w_choice   = (r_best_val == '0) ? r_rnd : r_best_idx;
    assign w_wb_stall = (r_cmd != CMD_END) && r_out_valid && !o_res.ready;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    logic           w_we;
    logic [TW-1:0]  w_waddr;
    logic [Q_W-1:0] w_wdata;
    logic           w_re;
    logic [TW-1:0]  w_raddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_we    = 1'b0;
        w_waddr = r_clr;
        w_wdata = '0;
        w_re    = 1'b0;
        w_raddr = r_prev_addr;
        unique case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                if (r_clr == TW'(TD - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_fire) begin
                    if (i_req.action == CMD_START || i_req.action == CMD_STEP) begin
                        n_state = S_ROW;
                    end else if (i_req.action == CMD_END) begin
                        n_state = S_PREV;
                    end
                end
            end
            S_ROW:  n_state = S_BASE;
            S_BASE: n_state = S_SCAN;
            S_SCAN: begin
                w_re    = 1'b1;
                w_raddr = r_base + TW'(r_idx);
                if (r_idx == AW'(NUM_ACTIONS - 1)) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: n_state = S_NEXT;
            S_NEXT: begin
                w_re    = 1'b1;
                w_raddr = r_base + TW'(w_choice);
                n_state = (r_cmd == CMD_START) ? S_WB : S_PREV;
            end
            S_PREV: begin
                w_re    = 1'b1;
                w_raddr = r_prev_addr;
                n_state = S_MUL1;
            end
            S_MUL1: n_state = S_DIFF;
            S_DIFF: n_state = S_MUL2;
            S_MUL2: n_state = S_WB;
            S_WB: begin
                if (!w_wb_stall) begin
                    // only a value that grew is stored
                    w_we    = (r_cmd != CMD_START) && !r_frozen && w_gt;
                    w_waddr = r_prev_addr;
                    w_wdata = w_nv_sat;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE);

    // ------------------------------------------------------------------
    // table RAM
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_prev_addr <= TW'(VOFF * NUM_ACTIONS);
            r_out_valid <= 1'b0;
            r_dv        <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            r_dv <= (r_state == S_SCAN);
            if (r_state == S_BASE) begin
                r_idx <= '0;
            end else if (r_state == S_SCAN) begin
                r_idx <= r_idx + 1'b1;
            end
            if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_WB && !w_wb_stall) begin
                if (r_cmd == CMD_END) begin
                    r_prev_addr <= TW'(VOFF * NUM_ACTIONS);
                end else begin
                    r_prev_addr <= r_base + TW'(r_act);
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_in_fire) begin
            r_cmd    <= i_req.action;
            r_pos    <= w_pos_c;
            r_vi     <= w_vi_c;
            r_rnd    <= w_rnd_c;
            r_reward <= i_req.reward;
            r_qnext  <= '0;
        end
        if (r_state == S_ROW) begin
            r_row <= RW'(int'(r_pos) * NUM_VELOCITIES + int'(r_vi));
        end
        if (r_state == S_BASE) begin
            r_base <= TW'(int'(r_row) * NUM_ACTIONS);
        end
        r_cmp_idx <= r_idx;
        // lowest index wins among equal maxima
        if (r_dv && (r_cmp_idx == '0 || w_gt)) begin
            r_best_val <= r_rdata;
            r_best_idx <= r_cmp_idx;
        end
        if (r_state == S_NEXT) begin
            r_act <= w_choice;
        end
        if (r_state == S_PREV && r_cmd == CMD_STEP) begin
            r_qnext <= r_rdata;
        end
        if (r_state == S_MUL1) begin
            r_q    <= r_rdata;
            r_prod <= w_prod;
        end
        if (r_state == S_DIFF) begin
            r_d16 <= w_d16;
        end
        if (r_state == S_MUL2) begin
            r_prod <= w_prod;
        end
        if (r_state == S_WB && !w_wb_stall && r_cmd != CMD_END) begin
            r_out_act <= CHOICE_W'(r_act);
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.chosen_action = r_out_act;

`ifndef SYNTHESIS
    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_CLEAR || r_state == S_WB))
        else $error("table written outside clear sweep or write-back");

    a_frozen_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && r_state != S_CLEAR) |-> !r_frozen)
        else $error("table written while learning frozen");

    a_result_from_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_WB)
        else $error("result beat raised outside write-back");

    a_action_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_act <= CHOICE_W'(NUM_ACTIONS - 1))
        else $error("chosen action out of range");
`endif

endmodule
`default_nettype wire
